>>> sv/positional_list_store_defines.svh
// ----------------------------------------------------------------------------
// positional list store assertion macros
// shared check macros for the positional list store, clocked on i_clk and
// held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PLS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("positional_list_store: check failed");

// consequent holds in the same cycle as the antecedent
`define PLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional_list_store: implication failed");

`endif

>>> sv/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// word types, operation codes and status codes of the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

    // operation codes
    localparam logic [2:0] OP_INS_POS  = 3'd0;
    localparam logic [2:0] OP_INS_HEAD = 3'd1;
    localparam logic [2:0] OP_INS_TAIL = 3'd2;
    localparam logic [2:0] OP_DEL_POS  = 3'd3;
    localparam logic [2:0] OP_DEL_HEAD = 3'd4;
    localparam logic [2:0] OP_DEL_TAIL = 3'd5;
    localparam logic [2:0] OP_SEARCH   = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_MISS  = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_list_in;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] found_position;
        logic [6:0] entry_count;
    } t_list_out;

endpackage

>>> sv/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of up to DEPTH values with positional insert, delete and
// key search, one entry moved or compared per cycle
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries a t_list_in word (operation,
//   1-based position, value). Output channel o_out_valid / i_out_ready carries
//   one t_list_out word per input word: status, found position, entry count.
//   Entries live in a single memory with one write and one registered read
//   port; a small sequencer walks it one slot per cycle. A positional insert
//   moves count-pos+1 entries, a delete count-pos entries, a search reads up
//   to count entries, stopping at the first hit. An error or the unused code
//   goes straight to the result state. o_in_ready is high only while the
//   sequencer is idle, from the cycle after the result is registered, so a
//   new word is accepted only once the last one has its result. The result
//   sits in an output register, so the next word is accepted while a result
//   waits; a finished item holds in its last state while the receiver stalls.
//   Synchronous reset empties the list (count to zero) and drops any pending
//   result; the entry memory is not cleared, since only slots below the count
//   are ever read.
// ----------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module positional_list_store
    import pls_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_list_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_list_out o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > 7) ? CW : 7) + 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [PW-1:0] EXT_ONE  = PW'(1);

    typedef enum logic [1:0] {S_IDLE, S_MOVE, S_SEARCH, S_DONE} t_state;

    // entry memory
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic [CW-1:0]          r_left, n_left;
    logic                   r_pend, n_pend;
    logic [AW-1:0]          r_ra, n_ra;
    logic [AW-1:0]          r_idx, n_idx;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic                   r_ins, n_ins;
    logic [2:0]             r_status, n_status;
    logic [6:0]             r_found, n_found;
    t_list_out              r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic                   w_in_fire;
    logic [63:0]            w_val64;
    logic [PW-1:0]          w_cnt_ext;
    logic [PW-1:0]          w_pos_ext;
    logic                   w_full;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [AW-1:0]          w_raddr;
    logic [PW-1:0]          w_found_ext;

    // decode results
    logic [2:0]             d_status;
    logic                   d_move;
    logic                   d_search;
    logic                   d_ins;
    logic [PW-1:0]          d_idx;
    logic [PW-1:0]          d_left_ins;
    logic [PW-1:0]          d_left_del;
    logic [PW-1:0]          d_ptr_del;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_val64     = {32'b0, i_in_data.value};
    assign w_cnt_ext   = {{(PW-CW){1'b0}}, r_count};
    assign w_pos_ext   = {{(PW-7){1'b0}}, i_in_data.position};
    assign w_full      = (r_count == CNT_FULL);
    assign w_found_ext = {{(PW-AW){1'b0}}, r_ra} + EXT_ONE;

    assign d_left_ins  = w_cnt_ext - d_idx;
    assign d_left_del  = w_cnt_ext - EXT_ONE - d_idx;
    assign d_ptr_del   = d_idx + EXT_ONE;

    always_comb begin
        d_status = ST_OK;
        d_move   = 1'b0;
        d_search = 1'b0;
        d_ins    = 1'b0;
        d_idx    = '0;
        unique case (i_in_data.operation) inside
            OP_INS_POS, OP_INS_HEAD, OP_INS_TAIL: begin
                if (i_in_data.operation == OP_INS_POS) begin
                    d_idx = w_pos_ext - EXT_ONE;
                end else if (i_in_data.operation == OP_INS_TAIL) begin
                    d_idx = w_cnt_ext;
                end
                // range check comes before the full check
                if ((i_in_data.operation == OP_INS_POS) &&
                    ((w_pos_ext == '0) || (w_pos_ext > w_cnt_ext + EXT_ONE))) begin
                    d_status = ST_RANGE;
                end else if (w_full) begin
                    d_status = ST_FULL;
                end else begin
                    d_move = 1'b1;
                    d_ins  = 1'b1;
                end
            end
            OP_DEL_POS, OP_DEL_HEAD, OP_DEL_TAIL: begin
                if (i_in_data.operation == OP_DEL_POS) begin
                    d_idx = w_pos_ext - EXT_ONE;
                end else if (i_in_data.operation == OP_DEL_TAIL) begin
                    d_idx = w_cnt_ext - EXT_ONE;
                end
                if (r_count == '0) begin
                    d_status = ST_EMPTY;
                end else if ((i_in_data.operation == OP_DEL_POS) &&
                             ((w_pos_ext == '0) || (w_pos_ext > w_cnt_ext))) begin
                    d_status = ST_RANGE;
                end else begin
                    d_move = 1'b1;
                end
            end
            OP_SEARCH: begin
                if (r_count == '0) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_search = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_ra        = r_ptr;
        n_idx       = r_idx;
        n_val       = r_val;
        n_ins       = r_ins;
        n_status    = r_status;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_val;
        w_raddr     = r_ptr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (w_in_fire) begin
                    n_status = d_status;
                    n_found  = '0;
                    n_val    = w_val64[VALUE_WIDTH-1:0];
                    n_ins    = d_ins;
                    n_idx    = d_idx[AW-1:0];
                    if (d_move && d_ins) begin
                        n_left  = d_left_ins[CW-1:0];
                        n_ptr   = r_count[AW-1:0] - AW'(1);
                        n_count = r_count + CNT_ONE;
                        n_state = S_MOVE;
                    end else if (d_move) begin
                        n_left  = d_left_del[CW-1:0];
                        n_ptr   = d_ptr_del[AW-1:0];
                        n_count = r_count - CNT_ONE;
                        n_state = S_MOVE;
                    end else if (d_search) begin
                        n_left  = r_count;
                        n_ptr   = '0;
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOVE, S_SEARCH: begin
                // issue one read per cycle while entries are left, registered data comes back in the next cycle
                if (r_left != '0) begin
                    n_pend = 1'b1;
                    n_left = r_left - CNT_ONE;
                    n_ptr  = r_ins ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
                end
                if (r_state == S_MOVE) begin
                    if (r_pend) begin
                        w_we    = 1'b1;
                        w_waddr = r_ins ? (r_ra + AW'(1)) : (r_ra - AW'(1));
                        w_wdata = r_rd_data;
                    end else if (r_left == '0) begin
                        // all moves are written; an insert drops the new value into the open gap
                        w_we    = r_ins;
                        n_state = S_DONE;
                    end
                end else begin
                    if (r_pend && (r_rd_data == r_val)) begin
                        n_status = ST_OK;
                        n_found  = w_found_ext[6:0];
                        n_pend   = 1'b0;
                        n_state  = S_DONE;
                    end else if (!r_pend && (r_left == '0)) begin
                        n_status = ST_MISS;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status         = r_status;
                    n_out.found_position = r_found;
                    n_out.entry_count    = w_cnt_ext[6:0];
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_ra     <= n_ra;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_ins    <= n_ins;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    `PLS_ASSERT_ALWAYS(a_count_cap, r_count <= CNT_FULL)
    `PLS_ASSERT_IMPL(a_write_in_move, w_we, r_state == S_MOVE)
    `PLS_ASSERT_IMPL(a_pend_busy, r_pend, (r_state == S_MOVE) || (r_state == S_SEARCH))
    `PLS_ASSERT_IMPL(a_found_ok, r_out_valid, (r_out.found_position == '0) || (r_out.status == ST_OK))

endmodule

>>> verif/positional_list_store_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_store_check
// watches both channels of the positional list store, keeps its own copy of
// the list, works out the result of every accepted word and compares each
// returned word field by field against the oldest outstanding one
// ----------------------------------------------------------------------------
module positional_list_store_check
    import pls_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_list_in  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_list_out i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_list_len
);

    logic [31:0] list_slots [DEPTH];
    int          list_len   = 0;
    int          fail_count = 0;
    t_list_out   pending_results [$];

    // shift the tail back by one and drop the value into the gap
    function automatic void open_slot(input int idx, input logic [31:0] v);
        int i;
        for (i = list_len; i > idx; i--) begin
            list_slots[i] = list_slots[i - 1];
        end
        list_slots[idx] = v;
        list_len++;
    endfunction

    function automatic void close_slot(input int idx);
        int i;
        for (i = idx; i + 1 < list_len; i++) begin
            list_slots[i] = list_slots[i + 1];
        end
        list_len--;
    endfunction

    function automatic t_list_out apply_list_op(input t_list_in w);
        t_list_out r;
        int        pos;
        int        i;
        r        = '0;
        r.status = ST_OK;
        pos      = int'(w.position);
        case (w.operation)
            OP_INS_POS: begin
                if (pos < 1 || pos > list_len + 1) r.status = ST_RANGE;
                else if (list_len >= DEPTH) r.status = ST_FULL;
                else open_slot(pos - 1, w.value);
            end
            OP_INS_HEAD: begin
                if (list_len >= DEPTH) r.status = ST_FULL;
                else open_slot(0, w.value);
            end
            OP_INS_TAIL: begin
                if (list_len >= DEPTH) r.status = ST_FULL;
                else open_slot(list_len, w.value);
            end
            OP_DEL_POS: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else if (pos < 1 || pos > list_len) r.status = ST_RANGE;
                else close_slot(pos - 1);
            end
            OP_DEL_HEAD: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else close_slot(0);
            end
            OP_DEL_TAIL: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            OP_SEARCH: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_MISS;
                    for (i = 0; i < list_len; i++) begin
                        if (r.status == ST_MISS && list_slots[i] == w.value) begin
                            r.status         = ST_OK;
                            r.found_position = 7'(i + 1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = 7'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_out want;
        t_list_out got;
        if (!i_rst_n) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            // a result can never belong to the word accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pending_results.size() == 0) begin
                    $error("result word with nothing outstanding: %h", got);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, got.found_position);
                        fail_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(apply_list_op(i_in_data));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_results.size();
        o_list_len   <= list_len;
    end

endmodule

>>> verif/positional_list_store_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_store_test
// drives the positional list store with a short directed sequence and then
// phases of random inserts, deletes and searches that fill and drain the
// list; both sides idle at random, the receiver holds off long enough to
// back the store up, and a separate checker judges every result word
// ----------------------------------------------------------------------------
module positional_list_store_test;
    import pls_pkg::*;

    localparam int         DEPTH       = 64;
    localparam int         ITEM_TARGET = 1400;
    localparam int         HOLD_CYCLES = 300;
    localparam logic [2:0] OP_UNUSED   = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_list_in  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_list_out o_out_data;

    int fail_count;
    int pending;
    int list_len;
    bit quiet    = 1'b0;
    int hold_req = 0;

    positional_list_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    positional_list_store_check #(
        .DEPTH (DEPTH)
    ) i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_list_len   (list_len)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_list_in list_word(input logic [2:0] op, input int pos,
                                           input logic [31:0] v);
        t_list_in w;
        w.operation = op;
        w.position  = 7'(pos);
        w.value     = v;
        return w;
    endfunction

    function automatic t_list_in pick_word(input t_mix mix, input int len);
        t_list_in w;
        int       r;
        int       ins_pct;
        int       del_pct;
        int       hi;
        case (mix)
            MIX_FILL:  begin ins_pct = 70; del_pct = 15; end
            MIX_DRAIN: begin ins_pct = 15; del_pct = 70; end
            default:   begin ins_pct = 40; del_pct = 40; end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_pct) w.operation = 3'($urandom_range(OP_INS_POS, OP_INS_TAIL));
        else if (r < ins_pct + del_pct) w.operation = 3'($urandom_range(OP_DEL_POS, OP_DEL_TAIL));
        else if (r < 97) w.operation = OP_SEARCH;
        else w.operation = OP_UNUSED;

        // positions cluster in range, with the edges and junk mixed in
        hi = (w.operation <= OP_INS_TAIL) ? len + 1 : ((len == 0) ? 1 : len);
        r  = $urandom_range(0, 99);
        if (r < 70) w.position = 7'($urandom_range(1, hi));
        else if (r < 78) w.position = 7'(len);
        else if (r < 86) w.position = 7'(len + 1);
        else if (r < 90) w.position = 7'(len + 2);
        else if (r < 94) w.position = '0;
        else w.position = 7'($urandom_range(0, 127));

        // a small pool of keys so searches hit often
        r = $urandom_range(0, 99);
        if (r < 45) begin
            w.value = 32'($urandom_range(0, 15)) - 32'd8;
        end else if (r < 55) begin
            case ($urandom_range(0, 3))
                0:       w.value = 32'h8000_0000;
                1:       w.value = 32'h7FFF_FFFF;
                2:       w.value = '1;
                default: w.value = '0;
            endcase
        end else begin
            w.value = $urandom;
        end
        return w;
    endfunction

    task automatic send_word(input t_list_in w);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        int hold_done;
        hold_done = 0;
        forever begin
            if (hold_req != hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = hold_req;
            end
            gap = gap_len();
            if (gap == 0) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int   sent;
        int   phase;
        int   span;
        t_mix mix;
        sent  = 0;
        phase = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        send_word(list_word(OP_SEARCH,   0, 32'd0));
        send_word(list_word(OP_DEL_POS,  1, 32'd0));
        send_word(list_word(OP_DEL_HEAD, 0, 32'd0));
        send_word(list_word(OP_DEL_TAIL, 0, 32'd0));
        send_word(list_word(OP_INS_POS,  0, 32'd5));
        send_word(list_word(OP_INS_POS,  2, 32'd5));
        // build a four entry list from the value extremes
        send_word(list_word(OP_INS_POS,  1, 32'h7FFF_FFFF));
        send_word(list_word(OP_INS_HEAD, 0, 32'h8000_0000));
        send_word(list_word(OP_INS_TAIL, 127, 32'hFFFF_FFFF));
        send_word(list_word(OP_INS_POS,  4, 32'd0));
        send_word(list_word(OP_INS_POS,  127, 32'd9));
        send_word(list_word(OP_INS_POS,  64, 32'd9));
        send_word(list_word(OP_SEARCH,   0, 32'h8000_0000));
        send_word(list_word(OP_SEARCH,   127, 32'hFFFF_FFFF));
        send_word(list_word(OP_SEARCH,   0, 32'd12345));
        send_word(list_word(OP_DEL_POS,  0, 32'd0));
        send_word(list_word(OP_DEL_POS,  5, 32'd0));
        send_word(list_word(OP_DEL_POS,  2, 32'd0));
        send_word(list_word(OP_UNUSED,   3, 32'd1));
        send_word(list_word(OP_DEL_HEAD, 0, 32'd0));
        send_word(list_word(OP_DEL_TAIL, 0, 32'd0));
        send_word(list_word(OP_DEL_POS,  1, 32'd0));
        send_word(list_word(OP_INS_POS,  1, 32'd3));

        while (sent < ITEM_TARGET) begin
            mix   = (phase == 0) ? MIX_FILL : t_mix'($urandom_range(0, 2));
            span  = (mix == MIX_FILL) ? $urandom_range(100, 200) : $urandom_range(40, 160);
            if (phase == 0 || $urandom_range(0, 4) == 0) wait_for_results();
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 1 || $urandom_range(0, 5) == 0) hold_req++;
            repeat (span) begin
                send_word(pick_word(mix, list_len));
                sent++;
            end
            phase++;
        end

        quiet = 1'b0;
        wait_for_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/pls_pkg.sv
sv/positional_list_store.sv
verif/positional_list_store_check.sv
verif/positional_list_store_test.sv
